// ----- hw/rtl/assc_pkg.sv -----
// shared constants, types and state codes of the audio sync sample correction block
package assc_pkg;

  // field widths
  localparam int DIFF_W = 32;
  localparam int MAG_W  = 33;
  localparam int SUM_W  = 48;
  localparam int NS_W   = 16;
  localparam int WANT_W = 17;
  localparam int WARM_W = 5;
  localparam int ADDR_W = 5;
  localparam int DATA_W = 32;

  localparam logic [WARM_W-1:0] AVG_WARMUP = 5'd20;

  localparam logic [SUM_W-1:0] SUM_MAX = 48'h7FFF_FFFF_FFFF;
  localparam logic [SUM_W-1:0] SUM_MIN = 48'h8000_0000_0000;

  // serial shift-add multiplier
  localparam int MUL_A_W   = 48;
  localparam int MUL_B_W   = 18;
  localparam int MUL_P_W   = 66;
  localparam int MUL_CNT_W = 5;
  localparam logic [MUL_CNT_W-1:0] MUL_STEPS = 5'd18;

  // serial divide by one hundred
  localparam int NP_W      = 23;
  localparam int QUOT_W    = 16;
  localparam int REM_W     = 7;
  localparam int DIV_CNT_W = 5;
  localparam logic [DIV_CNT_W-1:0] DIV_STEPS = 5'd23;
  localparam logic [REM_W:0]       DIV_BY    = 8'd100;

  localparam logic [6:0] PCT_MAX = 7'd100;

  typedef enum logic [2:0] {
    REG_SYNC_SOURCE,
    REG_AUDIO_PRESENT,
    REG_VIDEO_PRESENT,
    REG_DIFF_THRESHOLD,
    REG_AVG_COEF,
    REG_NOSYNC_LIMIT,
    REG_CORRECTION_PCT,
    REG_SAMPLE_RATE
  } reg_idx_e;

  typedef enum logic [1:0] {
    SRC_VIDEO,
    SRC_AUDIO,
    SRC_EXTERNAL
  } sync_src_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL_SUM,
    ST_SUM_UPD,
    ST_AVG_GO,
    ST_MUL_AVG,
    ST_MUL_DELTA,
    ST_MUL_PCT,
    ST_DIV,
    ST_FINISH,
    ST_DONE
  } state_e;

  // status of a serial arithmetic unit
  typedef struct packed {
    logic busy;
    logic done;
  } unit_status_t;

endpackage

// ----- hw/rtl/assc_mul.sv -----
// bit-serial shift-add multiplier, one multiplier bit per cycle
module assc_mul import assc_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic [MUL_A_W-1:0] a_i,
  input  logic [MUL_B_W-1:0] b_i,
  output unit_status_t       status_o,
  output logic [MUL_P_W-1:0] prod_o
);

  logic [MUL_P_W-1:0]   acc_q, acc_d;
  logic [MUL_P_W-1:0]   a_q, a_d;
  logic [MUL_B_W-1:0]   b_q, b_d;
  logic [MUL_CNT_W-1:0] cnt_q, cnt_d;
  logic                 busy_q, busy_d;
  logic                 done_q, done_d;

  always_comb begin
    acc_d  = acc_q;
    a_d    = a_q;
    b_d    = b_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      acc_d  = '0;
      a_d    = {{(MUL_P_W-MUL_A_W){1'b0}}, a_i};
      b_d    = b_i;
      cnt_d  = MUL_STEPS;
      busy_d = 1'b1;
    end else if (busy_q) begin
      // add the shifted multiplicand when the current multiplier bit is set
      if (b_q[0]) begin
        acc_d = acc_q + a_q;
      end
      a_d   = {a_q[MUL_P_W-2:0], 1'b0};
      b_d   = {1'b0, b_q[MUL_B_W-1:1]};
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == 1) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
    a_q   <= a_d;
    b_q   <= b_d;
  end

  assign status_o.busy = busy_q;
  assign status_o.done = done_q;
  assign prod_o        = acc_q;

endmodule

// ----- hw/rtl/assc_div100.sv -----
// restoring divider by one hundred, one quotient bit per cycle
module assc_div100 import assc_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [NP_W-1:0]   dividend_i,
  output unit_status_t      status_o,
  output logic [QUOT_W-1:0] quot_o,
  output logic [REM_W-1:0]  rem_o
);

  logic [NP_W-1:0]      x_q, x_d;
  logic [REM_W-1:0]     rem_q, rem_d;
  logic [DIV_CNT_W-1:0] cnt_q, cnt_d;
  logic                 busy_q, busy_d;
  logic                 done_q, done_d;
  logic [REM_W:0]       trial;
  logic                 ge;

  assign trial = {rem_q, x_q[NP_W-1]};
  assign ge    = (trial >= DIV_BY);

  always_comb begin
    x_d    = x_q;
    rem_d  = rem_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      x_d    = dividend_i;
      rem_d  = '0;
      cnt_d  = DIV_STEPS;
      busy_d = 1'b1;
    end else if (busy_q) begin
      // dividend bits shift out at the top, quotient bits shift in at the bottom
      rem_d = ge ? REM_W'(trial - DIV_BY) : REM_W'(trial);
      x_d   = {x_q[NP_W-2:0], ge};
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == 1) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q   <= x_d;
    rem_q <= rem_d;
  end

  assign status_o.busy = busy_q;
  assign status_o.done = done_q;
  assign quot_o        = x_q[QUOT_W-1:0];
  assign rem_o         = rem_q;

endmodule

// ----- hw/rtl/audio_sync_sample_correction_top.sv -----
// top level of the audio sync sample correction block
//
// One input transfer per audio frame carries the audio-minus-master clock
// difference (signed, 2^-20 s units), a flag that says whether the difference
// is defined, and the frame's sample count; one output transfer returns the
// sample count to play and a flag telling that this frame cleared the
// averaging filter. Items are worked one at a time. When audio is the master
// clock, or the difference is undefined or too large, the item goes straight
// to the done state and its result is loaded into the output register as soon
// as that register is free. Otherwise the filter update runs through a
// bit-serial multiplier (18 steps); a warm-up item stops after it, and an item
// whose averaged difference stays below the threshold stops after a second
// multiplication. A correcting item uses the multiplier four times and a
// bit-serial divide by one hundred (23 steps) for the clamp limits. The
// multiplier and divider handle one bit per cycle; a result still stalled in
// the output register holds the next one back. The next input is taken once
// the result sits in the output register, even while the output side stalls
// it. The registers sit on an APB-style port at byte address 4*index; the user
// must write them only while idle, and the block itself does not enforce it.
module audio_sync_sample_correction_top import assc_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  // input item channel
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [DIFF_W-1:0] clock_diff_i,
  input  logic              diff_valid_i,
  input  logic [NS_W-1:0]   frame_samples_i,
  // result channel
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [WANT_W-1:0] wanted_samples_o,
  output logic              filter_reset_o,
  // register port
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready
);

  // ---------------------------------------------------------------------------
  // configuration registers
  // ---------------------------------------------------------------------------
  logic [1:0]  src_q;
  logic        audio_q;
  logic        video_q;
  logic [30:0] thr_q;
  logic [15:0] coef_q;
  logic [30:0] limit_q;
  logic [6:0]  pct_q;
  logic [17:0] rate_q;

  logic     cfg_wr;
  reg_idx_e cfg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign cfg_idx = reg_idx_e'(paddr[ADDR_W-1:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      src_q   <= SRC_AUDIO;
      audio_q <= 1'b1;
      video_q <= 1'b1;
      thr_q   <= 31'd48234;
      coef_q  <= 16'd52057;
      limit_q <= 31'd10485760;
      pct_q   <= 7'd10;
      rate_q  <= 18'd48000;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_SYNC_SOURCE:    src_q   <= pwdata[1:0];
        REG_AUDIO_PRESENT:  audio_q <= pwdata[0];
        REG_VIDEO_PRESENT:  video_q <= pwdata[0];
        REG_DIFF_THRESHOLD: thr_q   <= pwdata[30:0];
        REG_AVG_COEF:       coef_q  <= pwdata[15:0];
        REG_NOSYNC_LIMIT:   limit_q <= pwdata[30:0];
        REG_CORRECTION_PCT: pct_q   <= pwdata[6:0];
        REG_SAMPLE_RATE:    rate_q  <= pwdata[17:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_SYNC_SOURCE:    prdata = {30'd0, src_q};
      REG_AUDIO_PRESENT:  prdata = {31'd0, audio_q};
      REG_VIDEO_PRESENT:  prdata = {31'd0, video_q};
      REG_DIFF_THRESHOLD: prdata = {1'b0, thr_q};
      REG_AVG_COEF:       prdata = {16'd0, coef_q};
      REG_NOSYNC_LIMIT:   prdata = {1'b0, limit_q};
      REG_CORRECTION_PCT: prdata = {25'd0, pct_q};
      REG_SAMPLE_RATE:    prdata = {14'd0, rate_q};
      default:            prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // item registers and filter state
  // ---------------------------------------------------------------------------
  state_e state_q, state_d;

  logic [DIFF_W-1:0] diff_q;
  logic [NS_W-1:0]   n_q;
  logic [MAG_W-1:0]  mag_q;
  logic [SUM_W-1:0]  sum_q;     // signed, 2^-20 s
  logic [WARM_W-1:0] warm_q;
  logic [31:0]       dmag_q;    // magnitude of the sample change
  logic [WANT_W-1:0] res_wanted_q;
  logic              res_reset_q;

  logic              out_valid_q;
  logic [WANT_W-1:0] out_wanted_q;
  logic              out_reset_q;

  // arithmetic units
  logic               mul_start;
  logic [MUL_A_W-1:0] mul_a;
  logic [MUL_B_W-1:0] mul_b;
  unit_status_t       mul_st;
  logic [MUL_P_W-1:0] mul_prod;
  logic               div_start;
  unit_status_t       div_st;
  logic [QUOT_W-1:0]  div_quot;
  logic [REM_W-1:0]   div_rem;

  assc_mul u_mul (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (mul_start),
    .a_i      (mul_a),
    .b_i      (mul_b),
    .status_o (mul_st),
    .prod_o   (mul_prod)
  );

  assc_div100 u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (mul_prod[NP_W-1:0]),
    .status_o   (div_st),
    .quot_o     (div_quot),
    .rem_o      (div_rem)
  );

  // ---------------------------------------------------------------------------
  // combinational datapath
  // ---------------------------------------------------------------------------
  logic             in_accept;
  logic             audio_master;
  logic [MAG_W-1:0] in_mag;
  logic             in_sync;
  logic             run_filter;
  logic [SUM_W-1:0] sum_abs;

  assign in_accept = in_valid_i && !in_stall_o;

  // master resolution
  always_comb begin
    case (sync_src_e'(src_q))
      SRC_VIDEO: audio_master = !video_q && audio_q;
      SRC_AUDIO: audio_master = audio_q;
      default:   audio_master = 1'b0;
    endcase
  end

  assign in_mag  = clock_diff_i[DIFF_W-1] ? (MAG_W'(0) - {1'b1, clock_diff_i})
                                          : {1'b0, clock_diff_i};
  assign in_sync = diff_valid_i && (in_mag < {2'b00, limit_q});
  assign run_filter = !audio_master && in_sync;

  assign sum_abs = sum_q[SUM_W-1] ? (SUM_W'(0) - sum_q) : sum_q;

  // filter update: diff + floor(coef * sum / 2^16), saturated
  logic [SUM_W-1:0]   f_trunc;
  logic [SUM_W-1:0]   f_ceil;
  logic [SUM_W+1:0]   f_sgn;
  logic [SUM_W+1:0]   s_full;
  logic [SUM_W-1:0]   s_sat;

  assign f_trunc = mul_prod[SUM_W+15:16];
  assign f_ceil  = f_trunc + {{(SUM_W-1){1'b0}}, |mul_prod[15:0]};
  assign f_sgn   = sum_q[SUM_W-1] ? ((SUM_W+2)'(0) - {2'b00, f_ceil})
                                  : {2'b00, f_trunc};
  assign s_full  = {{(SUM_W+2-DIFF_W){diff_q[DIFF_W-1]}}, diff_q} + f_sgn;

  always_comb begin
    if (s_full[SUM_W+1:SUM_W-1] == 3'b000 || s_full[SUM_W+1:SUM_W-1] == 3'b111) begin
      s_sat = s_full[SUM_W-1:0];
    end else if (s_full[SUM_W+1]) begin
      s_sat = SUM_MIN;
    end else begin
      s_sat = SUM_MAX;
    end
  end

  // averaged difference against the threshold
  logic avg_ge;
  assign avg_ge = (mul_prod[MUL_P_W-1:16] >= {19'd0, thr_q});

  logic [6:0] pct_sat;
  assign pct_sat = (pct_q > PCT_MAX) ? PCT_MAX : pct_q;

  // clamp of the corrected count to the percent window
  logic [WANT_W-1:0] quot_ceil;
  logic [WANT_W-1:0] lo;
  logic [WANT_W-1:0] hi;
  logic [33:0]       delta;
  logic [33:0]       w_sum;
  logic [WANT_W-1:0] w_clamp;

  assign quot_ceil = {1'b0, div_quot} + {{(WANT_W-1){1'b0}}, (div_rem != '0)};
  assign lo     = {1'b0, n_q} - quot_ceil;
  assign hi     = {1'b0, n_q} + {1'b0, div_quot};
  assign delta  = diff_q[DIFF_W-1] ? (34'd0 - {2'b00, dmag_q}) : {2'b00, dmag_q};
  assign w_sum  = {18'd0, n_q} + delta;

  always_comb begin
    if ($signed(w_sum) < $signed({17'd0, lo})) begin
      w_clamp = lo;
    end else if ($signed(w_sum) > $signed({17'd0, hi})) begin
      w_clamp = hi;
    end else begin
      w_clamp = w_sum[WANT_W-1:0];
    end
  end

  // output register is free when empty or being taken this cycle
  logic out_free;
  assign out_free = !out_valid_q || !out_stall_i;

  // ---------------------------------------------------------------------------
  // sequencer: next state
  // ---------------------------------------------------------------------------
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_accept) begin
          state_d = run_filter ? ST_MUL_SUM : ST_DONE;
        end
      end
      ST_MUL_SUM: begin
        if (mul_st.done) begin
          state_d = ST_SUM_UPD;
        end
      end
      ST_SUM_UPD: begin
        state_d = (warm_q < AVG_WARMUP) ? ST_DONE : ST_AVG_GO;
      end
      ST_AVG_GO: begin
        state_d = ST_MUL_AVG;
      end
      ST_MUL_AVG: begin
        if (mul_st.done) begin
          state_d = avg_ge ? ST_MUL_DELTA : ST_DONE;
        end
      end
      ST_MUL_DELTA: begin
        if (mul_st.done) begin
          state_d = ST_MUL_PCT;
        end
      end
      ST_MUL_PCT: begin
        if (mul_st.done) begin
          state_d = ST_DIV;
        end
      end
      ST_DIV: begin
        if (div_st.done) begin
          state_d = ST_FINISH;
        end
      end
      ST_FINISH: begin
        state_d = ST_DONE;
      end
      ST_DONE: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // ---------------------------------------------------------------------------
  // sequencer: outputs to the units and handshakes
  // ---------------------------------------------------------------------------
  logic out_load;

  always_comb begin
    in_stall_o = 1'b1;
    mul_start  = 1'b0;
    mul_a      = '0;
    mul_b      = '0;
    div_start  = 1'b0;
    out_load   = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_stall_o = 1'b0;
        // coef * |sum|
        if (in_accept && run_filter) begin
          mul_start = 1'b1;
          mul_a     = sum_abs;
          mul_b     = {2'b00, coef_q};
        end
      end
      ST_AVG_GO: begin
        // |sum| * (1 - coef)
        mul_start = 1'b1;
        mul_a     = sum_abs;
        mul_b     = MUL_B_W'(18'd65536 - {2'b00, coef_q});
      end
      ST_MUL_AVG: begin
        // |diff| * sample rate
        if (mul_st.done && avg_ge) begin
          mul_start = 1'b1;
          mul_a     = {{(MUL_A_W-MAG_W){1'b0}}, mag_q};
          mul_b     = rate_q;
        end
      end
      ST_MUL_DELTA: begin
        // frame samples * percent
        if (mul_st.done) begin
          mul_start = 1'b1;
          mul_a     = {{(MUL_A_W-NS_W){1'b0}}, n_q};
          mul_b     = {{(MUL_B_W-7){1'b0}}, pct_sat};
        end
      end
      ST_MUL_PCT: begin
        div_start = mul_st.done;
      end
      ST_DONE: begin
        out_load = out_free;
      end
      default: ;
    endcase
  end

  // ---------------------------------------------------------------------------
  // registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      sum_q       <= '0;
      warm_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      // filter clear on an undefined or out-of-range difference when audio is not the master
      if (state_q == ST_IDLE && in_accept && !audio_master && !in_sync) begin
        sum_q  <= '0;
        warm_q <= '0;
      end else if (state_q == ST_SUM_UPD) begin
        sum_q <= s_sat;
        if (warm_q < AVG_WARMUP) begin
          warm_q <= warm_q + 1'b1;
        end
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_IDLE && in_accept) begin
      diff_q       <= clock_diff_i;
      n_q          <= frame_samples_i;
      mag_q        <= in_mag;
      res_wanted_q <= {1'b0, frame_samples_i};
      res_reset_q  <= !audio_master && !in_sync;
    end
    if (state_q == ST_MUL_DELTA && mul_st.done) begin
      dmag_q <= mul_prod[51:20];
    end
    if (state_q == ST_FINISH) begin
      res_wanted_q <= w_clamp;
    end
    if (out_load) begin
      out_wanted_q <= res_wanted_q;
      out_reset_q  <= res_reset_q;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign wanted_samples_o = out_wanted_q;
  assign filter_reset_o   = out_reset_q;

  // ---------------------------------------------------------------------------
  // assertions
  // ---------------------------------------------------------------------------
  // warm-up counter never passes its limit
  assert property (@(posedge clk_i) disable iff (!rst_ni) warm_q <= AVG_WARMUP)
    else $error("warm-up count beyond limit");

  // a multiplier result only arrives while the sequencer waits for one
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    mul_st.done |-> (state_q == ST_MUL_SUM || state_q == ST_MUL_AVG ||
                     state_q == ST_MUL_DELTA || state_q == ST_MUL_PCT))
    else $error("multiplier result arrived in an unexpected state");

  // the divider only runs during the divide step
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_st.busy |-> state_q == ST_DIV)
    else $error("divider busy outside the divide step");

  // the sum update follows a finished multiplication
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(state_q == ST_SUM_UPD) |-> $past(mul_st.done))
    else $error("sum update without a finished product");

endmodule

// ----- test/tb_audio_sync_sample_correction_top.sv -----
// testbench for the audio sync sample correction block: directed table, random phases, predictor
`timescale 1ns / 100ps

module tb_audio_sync_sample_correction_top;
  import assc_pkg::*;

  // sync source code with no enum member, treated as external clock
  localparam logic [1:0] SRC_UNUSED = 2'd3;
  localparam longint SUM_HI = 64'sh0000_7FFF_FFFF_FFFF;
  localparam longint SUM_LO = -SUM_HI - 1;
  localparam int PHASES = 7;
  localparam int FRAMES_PER_PHASE = 100;
  localparam int STUCK_LIMIT = 4000;
  // idle tail after the last result, to catch any late or extra result transfer
  localparam int TAIL_CYCLES = 150;

  // one result transfer
  typedef struct packed {
    logic [WANT_W-1:0] wanted;
    logic              cleared;
  } frame_result_t;

  // one row of the directed table: a register write or a frame sent reps times
  typedef struct packed {
    logic              wr;
    reg_idx_e          idx;
    logic [31:0]       wval;
    logic [DIFF_W-1:0] diff;
    logic              dvalid;
    logic [NS_W-1:0]   nsamp;
    logic [4:0]        reps;
    logic              typed;
    logic [WANT_W-1:0] exp_wanted;
    logic              exp_cleared;
  } dir_row_t;

  localparam dir_row_t DIR_ROWS [15] = '{
    // audio is master after reset: counts pass through, even an undefined diff
    '{1'b0, REG_SYNC_SOURCE, 32'd0, 32'h7FFF_FFFF, 1'b1, 16'hFFFF, 5'd1, 1'b1, 17'd65535, 1'b0},
    '{1'b0, REG_SYNC_SOURCE, 32'd0, 32'h8000_0000, 1'b0, 16'd0, 5'd1, 1'b1, 17'd0, 1'b0},
    // video takes over as master
    '{1'b1, REG_SYNC_SOURCE, 32'(SRC_VIDEO), 32'd0, 1'b0, 16'd0, 5'd0, 1'b0, 17'd0, 1'b0},
    // undefined diff, most negative diff, diff exactly at the limit: all clear
    '{1'b0, REG_SYNC_SOURCE, 32'd0, 32'd0, 1'b0, 16'hFFFF, 5'd1, 1'b1, 17'd65535, 1'b1},
    '{1'b0, REG_SYNC_SOURCE, 32'd0, 32'h8000_0000, 1'b1, 16'd1, 5'd1, 1'b1, 17'd1, 1'b1},
    '{1'b0, REG_SYNC_SOURCE, 32'd0, 32'd10485760, 1'b1, 16'd48, 5'd1, 1'b1, 17'd48, 1'b1},
    // warm-up, first one just under the limit
    '{1'b0, REG_SYNC_SOURCE, 32'd0, 32'd10485759, 1'b1, 16'd1000, 5'd1, 1'b0, 17'd0, 1'b0},
    '{1'b0, REG_SYNC_SOURCE, 32'd0, 32'd524288, 1'b1, 16'd1000, 5'd19, 1'b0, 17'd0, 1'b0},
    // corrections: clamp high, clamp low, inside the band
    '{1'b0, REG_SYNC_SOURCE, 32'd0, 32'd524288, 1'b1, 16'd1000, 5'd1, 1'b0, 17'd0, 1'b0},
    '{1'b0, REG_SYNC_SOURCE, 32'd0, 32'hFFF8_0000, 1'b1, 16'd1000, 5'd1, 1'b0, 17'd0, 1'b0},
    '{1'b0, REG_SYNC_SOURCE, 32'd0, 32'd1000, 1'b1, 16'hFFFF, 5'd1, 1'b0, 17'd0, 1'b0},
    // percent above hundred acts as hundred: clamps to zero and to twice the frame
    '{1'b1, REG_CORRECTION_PCT, 32'd127, 32'd0, 1'b0, 16'd0, 5'd0, 1'b0, 17'd0, 1'b0},
    '{1'b0, REG_SYNC_SOURCE, 32'd0, 32'hFFE1_7B80, 1'b1, 16'd30000, 5'd1, 1'b0, 17'd0, 1'b0},
    '{1'b0, REG_SYNC_SOURCE, 32'd0, 32'h001E_8480, 1'b1, 16'hFFFF, 5'd1, 1'b0, 17'd0, 1'b0},
    '{1'b1, REG_CORRECTION_PCT, 32'd10, 32'd0, 1'b0, 16'd0, 5'd0, 1'b0, 17'd0, 1'b0}
  };

  logic              clk_i;
  logic              rst_ni;
  logic              in_valid_i;
  logic              in_stall_o;
  logic [DIFF_W-1:0] clock_diff_i;
  logic              diff_valid_i;
  logic [NS_W-1:0]   frame_samples_i;
  logic              out_valid_o;
  logic              out_stall_i;
  logic [WANT_W-1:0] wanted_samples_o;
  logic              filter_reset_o;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [DATA_W-1:0] pwdata;
  logic [DATA_W-1:0] prdata;
  logic              pready;

  // predictor copy of the registers
  logic [1:0]  cfg_sync;
  logic        cfg_audio;
  logic        cfg_video;
  logic [30:0] cfg_thresh;
  logic [15:0] cfg_coef;
  logic [30:0] cfg_limit;
  logic [6:0]  cfg_pct;
  logic [17:0] cfg_rate;

  // predictor copy of the filter state
  logic signed [SUM_W-1:0] diff_sum_q;
  logic [WARM_W-1:0]       warmup_q;

  frame_result_t predicted_counts [$];
  int unsigned   error_count;
  int unsigned   stuck_cycles;
  int            burst_left;

  // expectation typed into the table for the frame now on the input channel
  logic              cur_typed;
  logic [WANT_W-1:0] cur_exp_wanted;
  logic              cur_exp_cleared;

  audio_sync_sample_correction_top u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .clock_diff_i    (clock_diff_i),
    .diff_valid_i    (diff_valid_i),
    .frame_samples_i (frame_samples_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .wanted_samples_o(wanted_samples_o),
    .filter_reset_o  (filter_reset_o),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready)
  );

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  // sample count to play for one frame; advances the filter state copy
  function automatic frame_result_t predict_count(logic [DIFF_W-1:0] diff, logic dvalid,
                                                  logic [NS_W-1:0] nsamp);
    frame_result_t   res;
    logic            audio_master;
    longint          d;
    longint          s;
    longint          wanted;
    longint          lo;
    longint          hi;
    longint          delta;
    longint          pct;
    longint unsigned mag;
    longint unsigned smag;
    longint unsigned avg;
    longint unsigned dmag;
    // master resolution from the preferred source and the present bits
    if (cfg_sync == SRC_VIDEO) begin
      audio_master = !cfg_video && cfg_audio;
    end else if (cfg_sync == SRC_AUDIO) begin
      audio_master = cfg_audio;
    end else begin
      audio_master = 1'b0;
    end
    d = longint'($signed(diff));
    mag = (d < 0) ? -d : d;
    res.wanted = WANT_W'(nsamp);
    res.cleared = 1'b0;
    if (!audio_master) begin
      if (dvalid && mag < cfg_limit) begin
        // weighted sum, floor of the Q0.16 product, saturated to 48 bits
        s = d + ((longint'(cfg_coef) * longint'(diff_sum_q)) >>> 16);
        if (s > SUM_HI) s = SUM_HI;
        if (s < SUM_LO) s = SUM_LO;
        diff_sum_q = s[SUM_W-1:0];
        if (warmup_q < AVG_WARMUP) begin
          warmup_q = warmup_q + 1'b1;
        end else begin
          smag = (s < 0) ? -s : s;
          avg = (smag * (64'd65536 - cfg_coef)) >> 16;
          if (avg >= cfg_thresh) begin
            dmag = (mag * cfg_rate) >> 20;
            delta = (d < 0) ? -longint'(dmag) : longint'(dmag);
            pct = (cfg_pct > PCT_MAX) ? 100 : longint'(cfg_pct);
            lo = (longint'(nsamp) * (100 - pct)) / 100;
            hi = (longint'(nsamp) * (100 + pct)) / 100;
            wanted = longint'(nsamp) + delta;
            if (wanted < lo) wanted = lo;
            if (wanted > hi) wanted = hi;
            res.wanted = wanted[WANT_W-1:0];
          end
        end
      end else begin
        // undefined or too large a difference clears the filter
        diff_sum_q = '0;
        warmup_q = '0;
        res.cleared = 1'b1;
      end
    end
    return res;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    error_count++;
    $display("mismatch at %0t: %s, got %0d, expected %0d", $time, what, got, want);
  endtask

  // register write: setup cycle, then access cycle
  task automatic apb_write(reg_idx_e idx, logic [31:0] val);
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    case (idx)
      REG_SYNC_SOURCE:    cfg_sync = val[1:0];
      REG_AUDIO_PRESENT:  cfg_audio = val[0];
      REG_VIDEO_PRESENT:  cfg_video = val[0];
      REG_DIFF_THRESHOLD: cfg_thresh = val[30:0];
      REG_AVG_COEF:       cfg_coef = val[15:0];
      REG_NOSYNC_LIMIT:   cfg_limit = val[30:0];
      REG_CORRECTION_PCT: cfg_pct = val[6:0];
      REG_SAMPLE_RATE:    cfg_rate = val[17:0];
      default: ;
    endcase
    @(negedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(negedge clk_i);
  endtask

  // one input transfer, with a random gap between bursts
  task automatic send_frame(logic [DIFF_W-1:0] diff, logic dvalid, logic [NS_W-1:0] nsamp,
                            logic typed, logic [WANT_W-1:0] exp_w, logic exp_c);
    if (burst_left <= 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 10)) @(negedge clk_i);
      // now and then a long burst with no idling at all
      burst_left = ($urandom_range(0, 3) == 0) ? 60 : $urandom_range(1, 16);
    end
    burst_left--;
    cur_typed = typed;
    cur_exp_wanted = exp_w;
    cur_exp_cleared = exp_c;
    clock_diff_i <= diff;
    diff_valid_i <= dvalid;
    frame_samples_i <= nsamp;
    in_valid_i <= 1'b1;
    do @(posedge clk_i); while (in_stall_o);
    @(negedge clk_i);
  endtask

  // block must be idle before a register write
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (predicted_counts.size() != 0) @(negedge clk_i);
    @(negedge clk_i);
  endtask

  // input transfers feed the predictor, result transfers are checked
  always @(posedge clk_i) begin
    frame_result_t res;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        if (predicted_counts.size() == 0) begin
          report_mismatch("result transfer with no frame pending", wanted_samples_o, -1);
        end else begin
          res = predicted_counts.pop_front();
          if (wanted_samples_o !== res.wanted)
            report_mismatch("wanted_samples", wanted_samples_o, res.wanted);
          if (filter_reset_o !== res.cleared)
            report_mismatch("filter_reset", filter_reset_o, res.cleared);
        end
      end
      if (in_valid_i && !in_stall_o) begin
        res = predict_count(clock_diff_i, diff_valid_i, frame_samples_i);
        if (cur_typed) begin
          res.wanted = cur_exp_wanted;
          res.cleared = cur_exp_cleared;
        end
        predicted_counts.push_back(res);
      end
    end else begin
      // filter state after reset
      diff_sum_q = '0;
      warmup_q = '0;
    end
  end

  // watchdog: cycles with no transfer on any port
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
        (psel && penable && pwrite && pready)) begin
      stuck_cycles <= 0;
    end else if (stuck_cycles >= STUCK_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
  end

  // receiver: free stretches and trains of stall runs in random order
  initial begin : result_stall
    out_stall_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      if ($urandom_range(0, 3) == 0) begin
        out_stall_i <= 1'b0;
        repeat ($urandom_range(20, 80)) @(negedge clk_i);
      end else begin
        repeat ($urandom_range(2, 8)) begin
          out_stall_i <= 1'b1;
          repeat ($urandom_range(1, 12)) @(negedge clk_i);
          out_stall_i <= 1'b0;
          repeat ($urandom_range(1, 8)) @(negedge clk_i);
        end
      end
    end
  end

  initial begin : frame_source
    longint      base_mag;
    longint      mag_l;
    logic        neg;
    logic [31:0] mask;
    logic [31:0] d;
    logic        dv;
    logic [15:0] nsamp;
    logic [1:0]  src;
    int          roll;
    // every input known from time zero
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    clock_diff_i = '0;
    diff_valid_i = 1'b0;
    frame_samples_i = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    burst_left = 0;
    cur_typed = 1'b0;
    cur_exp_wanted = '0;
    cur_exp_cleared = 1'b0;
    base_mag = 0;
    neg = 1'b0;
    // register values after reset
    cfg_sync = SRC_AUDIO;
    cfg_audio = 1'b1;
    cfg_video = 1'b1;
    cfg_thresh = 31'd48234;
    cfg_coef = 16'd52057;
    cfg_limit = 31'd10485760;
    cfg_pct = 7'd10;
    cfg_rate = 18'd48000;
    repeat (2) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // directed table
    foreach (DIR_ROWS[r]) begin
      if (DIR_ROWS[r].wr) begin
        wait_drained();
        apb_write(DIR_ROWS[r].idx, DIR_ROWS[r].wval);
      end else begin
        repeat (DIR_ROWS[r].reps)
          send_frame(DIR_ROWS[r].diff, DIR_ROWS[r].dvalid, DIR_ROWS[r].nsamp,
                     DIR_ROWS[r].typed, DIR_ROWS[r].exp_wanted, DIR_ROWS[r].exp_cleared);
      end
    end

    // random phases, each with its own register setting
    for (int p = 0; p < PHASES; p++) begin
      wait_drained();
      case (p)
        0, 6:    src = SRC_VIDEO;
        1, 5:    src = SRC_EXTERNAL;
        2:       src = SRC_UNUSED;
        3:       src = SRC_VIDEO;
        default: src = SRC_AUDIO;
      endcase
      apb_write(REG_SYNC_SOURCE, 32'(src));
      apb_write(REG_AUDIO_PRESENT, 32'($urandom_range(0, 1)));
      // no video on phase 3, so video preference falls back
      apb_write(REG_VIDEO_PRESENT, (p == 3) ? 32'd0 : 32'd1);
      // low extremes on phase 1 but for the limit, high extremes on phase 2, zero threshold on phase 5 too
      apb_write(REG_DIFF_THRESHOLD, (p == 1 || p == 5) ? 32'd0 :
                (p == 2) ? 32'h7FFF_FFFF : 32'($urandom_range(0, 200000)));
      apb_write(REG_AVG_COEF, (p == 1) ? 32'd0 : (p == 2) ? 32'd65535 :
                32'($urandom_range(0, 65535)));
      // phase 5 lets only a zero diff through, phase 6 clears on every frame
      apb_write(REG_NOSYNC_LIMIT, (p == 1 || p == 2) ? 32'h7FFF_FFFF : (p == 5) ? 32'd1 :
                (p == 6) ? 32'd0 : 32'($urandom_range(1 << 20, 1 << 26)));
      apb_write(REG_CORRECTION_PCT, (p == 1) ? 32'd0 : (p == 2) ? 32'd127 :
                (p == 3) ? 32'd100 : 32'($urandom_range(0, 127)));
      apb_write(REG_SAMPLE_RATE, (p == 1) ? 32'd1 : (p == 2) ? 32'h3FFFF :
                (p == 3) ? 32'd192000 : 32'($urandom_range(1, 192000)));
      for (int k = 0; k < FRAMES_PER_PHASE; k++) begin
        roll = $urandom_range(0, 31);
        dv = 1'b1;
        if (roll == 0) begin
          // undefined difference
          dv = 1'b0;
          d = $urandom;
        end else if (roll == 1) begin
          // any difference, mostly past the limit except on phases 1 and 2
          d = $urandom;
        end else begin
          // drift around a base value so the average can build up
          if (k == 0 || $urandom_range(0, 31) == 0) begin
            mask = (32'h1 << $urandom_range(4, 31)) - 32'h1;
            base_mag = (cfg_limit == 0) ? 0 : longint'($urandom & mask) % cfg_limit;
            neg = 1'($urandom_range(0, 1));
          end
          mag_l = (cfg_limit == 0) ? 0 :
                  (base_mag + $urandom_range(0, 32'(base_mag >> 3))) % cfg_limit;
          if ($urandom_range(0, 7) == 0)
            d = neg ? 32'(mag_l) : -32'(mag_l);
          else
            d = neg ? -32'(mag_l) : 32'(mag_l);
        end
        roll = $urandom_range(0, 15);
        nsamp = (roll == 0) ? 16'd0 : (roll == 1) ? 16'hFFFF : 16'($urandom_range(0, 65535));
        send_frame(d, dv, nsamp, 1'b0, '0, 1'b0);
      end
    end

    wait_drained();
    repeat (TAIL_CYCLES) @(negedge clk_i);
    if (error_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
